// ===== hw/rtl/kdlr_pkg.sv =====
package kdlr_pkg;

  localparam int unsigned MAX_KEYS = 3;
  localparam int unsigned SLOTS = 2 * MAX_KEYS;
  localparam int unsigned SEL_W = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CODE_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME_KEY0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_SPEED_KEY0 = 3'd3;

  localparam logic [15:0] LONG_TIME_RESET = 16'd100;
  localparam logic [7:0] REPEAT_SPEED_RESET = 8'd0;
  localparam logic [7:0] REPEAT_COUNT_MAX = 8'd255;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic              first_valid;
    logic [CODE_W-1:0] first_code;
    logic              second_valid;
    logic [CODE_W-1:0] second_code;
  } lane_evt_t;

  function automatic logic [CODE_W-1:0] code_down(input int unsigned k);
    return CODE_W'(3 * k + 1);
  endfunction

  function automatic logic [CODE_W-1:0] code_up(input int unsigned k);
    return CODE_W'(3 * k + 2);
  endfunction

  function automatic logic [CODE_W-1:0] code_long(input int unsigned k);
    return CODE_W'(3 * k + 3);
  endfunction

endpackage

// ===== hw/rtl/key_debounce_long_repeat.sv =====
// Debounces up to three keys and turns presses into key events. Each input beat is one scan
// tick; every key has its own lane that filters the raw level, tracks hold time and repeat
// spacing, and can raise up to two events per tick. A tick is taken whenever the
// two-entry event buffer has room, so ticks may follow back to back; the events of one tick
// then leave one beat per cycle on the output while m_axis_tready is high, key 0 first and
// a key's down code before its long or repeat code, with tlast on the last event of the
// tick. A tick that raises no event gives no output beat. A tick raises at most six events,
// and the output port sets the sustained rate. Registers 0 to 2 are the long-press times
// and 3 to 5 the repeat spacings of keys 0 to 2; write them only while the block is idle.
module key_debounce_long_repeat #(
  parameter int KEYS = 3,
  parameter int FILTER_TICKS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // key_down[2:0], zero[7:3]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // event_code[3:0], stable_states[6:4], zero[7]
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [kdlr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kdlr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kdlr_pkg::*;

  cfg_wr_t             cfg;
  lane_evt_t           evts [MAX_KEYS];
  logic [MAX_KEYS-1:0] stable;
  logic                tick;
  logic [CODE_W-1:0]   out_code;
  logic [MAX_KEYS-1:0] out_stable;

  assign cfg = '{we: cfg_we, index: cfg_index, data: cfg_data};
  assign tick = s_axis_tvalid && s_axis_tready;

  for (genvar k = 0; k < MAX_KEYS; k++) begin : g_lane
    if (k < KEYS) begin : g_used
      kdlr_lane #(
        .KEY_INDEX(k),
        .FILTER_TICKS(FILTER_TICKS)
      ) u_lane (
        .clk(clk),
        .rst(rst),
        .tick(tick),
        .raw(s_axis_tdata[k]),
        .cfg(cfg),
        .evt(evts[k]),
        .pressed_next(stable[k])
      );
    end else begin : g_unused
      assign evts[k] = '0;
      assign stable[k] = 1'b0;
    end
  end

  kdlr_merge u_merge (
    .clk(clk),
    .rst(rst),
    .push_tick(tick),
    .evts(evts),
    .stable(stable),
    .space(s_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_code(out_code),
    .out_stable(out_stable),
    .out_last(m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_stable, out_code};

  a_full_has_output: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("event buffer full with nothing to send");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[3:0] != 4'd0) && (m_axis_tdata[3:0] <= 4'(3 * KEYS)))
    else $error("event code outside the keys in use");

  a_unused_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tdata[6:4] >> KEYS) == 3'd0))
    else $error("stable bit set for a key that is not in use");

  a_hold_beat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled event beat changed");

endmodule

// ===== hw/rtl/kdlr_lane.sv =====
module kdlr_lane #(
  parameter int KEY_INDEX = 0,
  parameter int FILTER_TICKS = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              tick,
  input  logic              raw,
  input  kdlr_pkg::cfg_wr_t cfg,
  output kdlr_pkg::lane_evt_t evt,
  output logic              pressed_next
);
  import kdlr_pkg::*;

  localparam logic [7:0] FILT = 8'(FILTER_TICKS);
  localparam logic [7:0] TOP = 8'(2 * FILTER_TICKS);
  localparam logic [7:0] DC_RESET = 8'(FILTER_TICKS / 2);

  logic [7:0]  debounce_count, debounce_count_next;
  logic        key_pressed;
  logic [15:0] hold_count, hold_count_next;
  logic [7:0]  repeat_count, repeat_count_next;
  logic [7:0]  repeat_inc;
  logic [15:0] long_time;
  logic [7:0]  repeat_speed;
  logic        hit_long, hit_repeat;

  assign hit_long = cfg.we && (cfg.index == REG_LONG_TIME_KEY0 + CFG_IDX_W'(KEY_INDEX));
  assign hit_repeat = cfg.we && (cfg.index == REG_REPEAT_SPEED_KEY0 + CFG_IDX_W'(KEY_INDEX));

  always_comb begin
    debounce_count_next = debounce_count;
    pressed_next = key_pressed;
    hold_count_next = hold_count;
    repeat_count_next = repeat_count;
    repeat_inc = (repeat_count < REPEAT_COUNT_MAX) ? repeat_count + 8'd1 : repeat_count;
    evt = '0;
    if (raw) begin
      if (debounce_count < FILT) begin
        debounce_count_next = FILT;
      end else if (debounce_count < TOP) begin
        debounce_count_next = debounce_count + 8'd1;
      end else begin
        if (!key_pressed) begin
          pressed_next = 1'b1;
          evt.first_valid = 1'b1;
          evt.first_code = code_down(KEY_INDEX);
        end
        if (long_time != '0) begin
          if (hold_count < long_time) begin
            hold_count_next = hold_count + 16'd1;
            if (hold_count_next == long_time) begin
              evt.second_valid = 1'b1;
              evt.second_code = code_long(KEY_INDEX);
            end
          end else if (repeat_speed != '0) begin
            if (repeat_inc >= repeat_speed) begin
              repeat_count_next = '0;
              evt.second_valid = 1'b1;
              evt.second_code = code_down(KEY_INDEX);
            end else begin
              repeat_count_next = repeat_inc;
            end
          end
        end
      end
    end else begin
      if (debounce_count > FILT) begin
        debounce_count_next = FILT;
      end else if (debounce_count != '0) begin
        debounce_count_next = debounce_count - 8'd1;
      end else if (key_pressed) begin
        pressed_next = 1'b0;
        evt.first_valid = 1'b1;
        evt.first_code = code_up(KEY_INDEX);
      end
      hold_count_next = '0;
      repeat_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_count <= DC_RESET;
      key_pressed <= 1'b0;
      hold_count <= '0;
      repeat_count <= '0;
      long_time <= LONG_TIME_RESET;
      repeat_speed <= REPEAT_SPEED_RESET;
    end else begin
      if (tick) begin
        debounce_count <= debounce_count_next;
        key_pressed <= pressed_next;
        hold_count <= hold_count_next;
      end
      if (hit_long) begin
        long_time <= cfg.data;
      end
      if (hit_repeat) begin
        repeat_speed <= cfg.data[7:0];
      end
      if (hit_long || hit_repeat) begin
        repeat_count <= '0;
      end else if (tick) begin
        repeat_count <= repeat_count_next;
      end
    end
  end

endmodule

// ===== hw/rtl/kdlr_merge.sv =====
module kdlr_merge (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push_tick,
  input  kdlr_pkg::lane_evt_t     evts [kdlr_pkg::MAX_KEYS],
  input  logic [kdlr_pkg::MAX_KEYS-1:0] stable,
  output logic                    space,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [kdlr_pkg::CODE_W-1:0] out_code,
  output logic [kdlr_pkg::MAX_KEYS-1:0] out_stable,
  output logic                    out_last
);
  import kdlr_pkg::*;

  logic [SLOTS-1:0]    rec_mask [2];
  logic [CODE_W-1:0]   rec_code [2][SLOTS];
  logic [MAX_KEYS-1:0] rec_stable [2];
  logic                wr_ptr, rd_ptr;
  logic [1:0]          count, count_next;

  logic [SLOTS-1:0]    new_mask, head_mask;
  logic [CODE_W-1:0]   new_code [SLOTS];
  logic [SEL_W-1:0]    sel;
  logic                found, push, take, pop;

  always_comb begin
    for (int k = 0; k < MAX_KEYS; k++) begin
      new_mask[2*k] = evts[k].first_valid;
      new_mask[2*k+1] = evts[k].second_valid;
      new_code[2*k] = evts[k].first_code;
      new_code[2*k+1] = evts[k].second_code;
    end
  end

  always_comb begin
    head_mask = rec_mask[rd_ptr];
    sel = '0;
    found = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!found && head_mask[i]) begin
        sel = SEL_W'(i);
        found = 1'b1;
      end
    end
  end

  assign space = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_code = rec_code[rd_ptr][sel];
  assign out_stable = rec_stable[rd_ptr];
  assign out_last = ((head_mask & (head_mask - SLOTS'(1))) == '0);

  assign push = push_tick && (new_mask != '0);
  assign take = out_valid && out_ready;
  assign pop = take && out_last;
  assign count_next = count + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !out_last) begin
      rec_mask[rd_ptr][sel] <= 1'b0;
    end
    if (push) begin
      rec_mask[wr_ptr] <= new_mask;
      rec_code[wr_ptr] <= new_code;
      rec_stable[wr_ptr] <= stable;
    end
  end

endmodule

// ===== tb/sv/key_debounce_long_repeat_tb.sv =====
`timescale 1ns / 100ps

typedef struct packed {
  logic [3:0] code;
  logic [2:0] stable;
  logic       last;
} key_event_t;

class key_event_board;
  localparam int KEY_COUNT = 3;
  localparam int FILTER = 5;
  localparam int CODES_PER_KEY = 3;
  localparam int EVT_DOWN = 1;
  localparam int EVT_UP = 2;
  localparam int EVT_LONG = 3;

  logic [15:0] long_time [KEY_COUNT];
  logic [7:0]  repeat_speed [KEY_COUNT];
  logic [7:0]  debounce [KEY_COUNT];
  logic        pressed [KEY_COUNT];
  logic [15:0] hold [KEY_COUNT];
  logic [7:0]  repeat_cnt [KEY_COUNT];
  key_event_t  expected_q [$];
  int          errors;

  function new();
    for (int k = 0; k < KEY_COUNT; k++) begin
      long_time[k] = kdlr_pkg::LONG_TIME_RESET;
      repeat_speed[k] = kdlr_pkg::REPEAT_SPEED_RESET;
      debounce[k] = 8'(FILTER / 2);
      pressed[k] = 1'b0;
      hold[k] = '0;
      repeat_cnt[k] = '0;
    end
    errors = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void note_write(logic [2:0] idx, logic [15:0] value);
    int k;
    if (idx < kdlr_pkg::REG_REPEAT_SPEED_KEY0) begin
      k = int'(idx) - int'(kdlr_pkg::REG_LONG_TIME_KEY0);
      long_time[k] = value;
      repeat_cnt[k] = '0;
    end else if (idx < kdlr_pkg::REG_REPEAT_SPEED_KEY0 + kdlr_pkg::MAX_KEYS) begin
      k = int'(idx) - int'(kdlr_pkg::REG_REPEAT_SPEED_KEY0);
      repeat_speed[k] = value[7:0];
      repeat_cnt[k] = '0;
    end
  endfunction

  function void note_tick(logic [2:0] keys);
    logic [3:0] codes [$];
    logic [2:0] stable;
    key_event_t ev;
    for (int k = 0; k < KEY_COUNT; k++) begin
      if (keys[k]) begin
        if (debounce[k] < FILTER) begin
          debounce[k] = 8'(FILTER);
        end else if (debounce[k] < 2 * FILTER) begin
          debounce[k] = debounce[k] + 8'd1;
        end else begin
          if (!pressed[k]) begin
            pressed[k] = 1'b1;
            codes.push_back(4'(CODES_PER_KEY * k + EVT_DOWN));
          end
          if (long_time[k] != 0) begin
            if (hold[k] < long_time[k]) begin
              hold[k] = hold[k] + 16'd1;
              if (hold[k] == long_time[k]) begin
                codes.push_back(4'(CODES_PER_KEY * k + EVT_LONG));
              end
            end else if (repeat_speed[k] != 0) begin
              if (repeat_cnt[k] != kdlr_pkg::REPEAT_COUNT_MAX) begin
                repeat_cnt[k] = repeat_cnt[k] + 8'd1;
              end
              if (repeat_cnt[k] >= repeat_speed[k]) begin
                repeat_cnt[k] = '0;
                codes.push_back(4'(CODES_PER_KEY * k + EVT_DOWN));
              end
            end
          end
        end
      end else begin
        if (debounce[k] > FILTER) begin
          debounce[k] = 8'(FILTER);
        end else if (debounce[k] != 0) begin
          debounce[k] = debounce[k] - 8'd1;
        end else if (pressed[k]) begin
          pressed[k] = 1'b0;
          codes.push_back(4'(CODES_PER_KEY * k + EVT_UP));
        end
        hold[k] = '0;
        repeat_cnt[k] = '0;
      end
    end
    stable = '0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      stable[k] = pressed[k];
    end
    foreach (codes[i]) begin
      ev.code = codes[i];
      ev.stable = stable;
      ev.last = (i == codes.size() - 1);
      expected_q.push_back(ev);
    end
  endfunction

  function void check_event(logic [3:0] code, logic [2:0] stable, logic last);
    key_event_t ev;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: event beat with none expected, code %0d stable %b last %b",
               $time, code, stable, last);
      return;
    end
    ev = expected_q.pop_front();
    if (code !== ev.code) begin
      errors++;
      $display("%0t: event_code expected %0d actual %0d", $time, ev.code, code);
    end
    if (stable !== ev.stable) begin
      errors++;
      $display("%0t: stable_states expected %b actual %b", $time, ev.stable, stable);
    end
    if (last !== ev.last) begin
      errors++;
      $display("%0t: last_event expected %b actual %b", $time, ev.last, last);
    end
  endfunction
endclass

module key_debounce_long_repeat_tb;
  import kdlr_pkg::*;

  localparam int KEYS = 3;
  localparam int FILTER_TICKS = 5;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  key_event_board board;
  bit src_steady = 1'b0;
  bit sink_steady = 1'b0;
  int stall_left = 0;
  int cycles = 0;

  key_debounce_long_repeat #(
    .KEYS(KEYS),
    .FILTER_TICKS(FILTER_TICKS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!sink_steady && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      board.check_event(m_axis_tdata[3:0], m_axis_tdata[6:4], m_axis_tlast);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_tick(input logic [2:0] keys);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, keys};
    do @(posedge clk); while (!s_axis_tready);
    board.note_tick(keys);
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    board.note_write(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Leave a short quiet stretch after the last event before the registers change.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int rand_items;
    int segs;
    int len;
    int phase;
    logic [2:0] pattern;
    logic [2:0] last_keys;
    logic [15:0] value;
    board = new();
    rand_items = 0;
    phase = 0;
    last_keys = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A long time of one on every key makes the first stable press raise all six events.
    write_reg(REG_LONG_TIME_KEY0 + 3'd0, 16'd1);
    write_reg(REG_LONG_TIME_KEY0 + 3'd1, 16'd1);
    write_reg(REG_LONG_TIME_KEY0 + 3'd2, 16'd1);
    write_reg(REG_REPEAT_SPEED_KEY0 + 3'd0, 16'd0);
    write_reg(REG_REPEAT_SPEED_KEY0 + 3'd1, 16'd2);
    write_reg(REG_REPEAT_SPEED_KEY0 + 3'd2, 16'hFF01);
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h1234);
    repeat (10) send_tick(3'b111);
    send_tick(3'b101);
    send_tick(3'b010);
    repeat (8) send_tick(3'b000);

    while (rand_items < 70) begin
      drain();
      phase++;
      for (int k = 0; k < KEYS; k++) begin
        case ($urandom_range(0, 9))
          0: value = 16'd0;
          1: value = 16'd1;
          2: value = 16'hFFFF;
          default: value = phase[0] ? 16'($urandom_range(2, 10)) : 16'($urandom_range(11, 400));
        endcase
        write_reg(REG_LONG_TIME_KEY0 + 3'(k), value);
        case ($urandom_range(0, 7))
          0: value[7:0] = 8'd0;
          1: value[7:0] = 8'd1;
          2: value[7:0] = 8'd255;
          default: value[7:0] = 8'($urandom_range(1, 4));
        endcase
        value[15:8] = 8'($urandom);
        write_reg(REG_REPEAT_SPEED_KEY0 + 3'(k), value);
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom));
      end
      src_steady = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      segs = $urandom_range(3, 6);
      for (int s = 0; s < segs; s++) begin
        if ($urandom_range(0, 4) == 0) begin
          len = $urandom_range(1, 4);
          repeat (len) begin
            last_keys = 3'($urandom_range(0, 7));
            send_tick(last_keys);
          end
        end else begin
          pattern = (s == 0 && $urandom_range(0, 1) == 1) ? last_keys : 3'($urandom_range(0, 7));
          len = $urandom_range(1, 20);
          repeat (len) send_tick(pattern);
          last_keys = pattern;
        end
        rand_items += len;
      end
    end

    drain();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
